// ===== hw/rtl/rbsi_pkg.sv =====
`timescale 1ns / 1ps
package rbsi_pkg;

   localparam int NUM_BOX_REGS       = 6;
   localparam int CSR_INDEX_W        = 3;
   localparam int DIV_BITS_PER_STAGE = 2;
   localparam int QUOT_W             = 32;
   localparam int DIV_STAGES         = QUOT_W / DIV_BITS_PER_STAGE;

   localparam logic [CSR_INDEX_W-1:0] CSR_BOX_MIN_X = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_BOX_MIN_Y = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_BOX_MIN_Z = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_BOX_MAX_X = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_BOX_MAX_Y = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] CSR_BOX_MAX_Z = 3'd5;

   localparam logic signed [31:0] Q_MAX = 32'sh7fff_ffff;
   localparam logic signed [31:0] Q_MIN = 32'sh8000_0000;

   typedef struct packed {
      logic signed [31:0] origin_x;
      logic signed [31:0] origin_y;
      logic signed [31:0] origin_z;
      logic signed [31:0] direction_x;
      logic signed [31:0] direction_y;
      logic signed [31:0] direction_z;
      logic signed [31:0] limit_near;
      logic signed [31:0] limit_far;
   } req_type;

   typedef struct packed {
      logic signed [31:0] entry_distance;
      logic signed [31:0] exit_distance;
      logic               box_hit;
   } rsp_type;

   // per-request flags and limits that ride along with the divide
   typedef struct packed {
      logic [2:0]         dir_zero;
      logic [2:0]         dir_neg;
      logic [2:0]         org_in;
      logic signed [31:0] lim_near;
      logic signed [31:0] lim_far;
   } side_type;

   typedef struct packed {
      logic [31:0] rem;
      logic [31:0] num;
      logic [31:0] q;
      logic        ovf;
      logic        neg;
   } div_lane_type;

   typedef struct packed {
      div_lane_type [5:0] lane;
      logic [2:0][31:0]   dirmag;
      side_type           side;
   } div_type;

   function automatic div_lane_type div_step(div_lane_type l, logic [31:0] dvs);
      logic [32:0]  r;
      div_lane_type o;
      o = l;
      for (int s = 0; s < DIV_BITS_PER_STAGE; s++) begin
         r     = {o.rem, o.num[31]};
         o.num = {o.num[30:0], 1'b0};
         if (r >= {1'b0, dvs}) begin
            o.rem = 32'(r - {1'b0, dvs});
            o.q   = {o.q[30:0], 1'b1};
         end else begin
            o.rem = r[31:0];
            o.q   = {o.q[30:0], 1'b0};
         end
      end
      return o;
   endfunction

endpackage

// ===== hw/rtl/ray_box_slab_intersect_unit.sv =====
`timescale 1ns / 1ps
// channel   direction  handshake              payload
// req_      in         req_valid / req_stall  req_data  (rbsi_pkg::req_type)
// rsp_      out        rsp_valid / rsp_stall  rsp_data  (rbsi_pkg::rsp_type)
// csr_      in         csr_valid / csr_ready  csr_index, csr_data
//
// one request per cycle while req_stall is low; 22 register stages. the depth
// is set by the plane-distance divider: 32 quotient bits, two per stage, six
// dividers side by side (two planes per axis).
// synchronous active-high reset clears all valid bits and the box registers.
// each stage advances when empty or when the stage after it advances, so a
// stalled rsp fills the bubbles upstream before req_stall rises.
module ray_box_slab_intersect_unit
   import rbsi_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  req_type                req_data,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output rsp_type                rsp_data,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [31:0]            csr_data
);

   localparam int ST_DIFF = 0;
   localparam int ST_MAG  = 1;
   localparam int ST_INIT = 2;
   localparam int ST_DIV0 = 3;
   localparam int ST_SAT  = ST_DIV0 + DIV_STAGES;
   localparam int ST_RED  = ST_SAT + 1;
   localparam int ST_OUT  = ST_RED + 1;
   localparam int NST     = ST_OUT + 1;

   typedef struct packed {
      logic [5:0][32:0] diff;
      logic [2:0][31:0] dir;
      side_type         side;
   } diff_st_type;

   typedef struct packed {
      logic [5:0][31:0] dmag;
      logic [5:0]       qneg;
      logic [2:0][31:0] dirmag;
      side_type         side;
   } mag_st_type;

   typedef struct packed {
      logic [2:0][31:0] enter;
      logic [2:0][31:0] leave;
      side_type         side;
   } sat_st_type;

   typedef struct packed {
      logic signed [31:0] entry;
      logic signed [31:0] exitd;
   } red_st_type;

   logic [NUM_BOX_REGS-1:0][31:0] box_ff;
   logic [NST-1:0]                vld_ff;
   logic [NST-1:0]                adv;

   diff_st_type diff_ff, diff_in;
   mag_st_type  mag_ff, mag_in;
   div_type     init_ff, init_in;
   div_type     div_ff [DIV_STAGES];
   div_type     div_in [DIV_STAGES];
   sat_st_type  sat_ff, sat_in;
   red_st_type  red_ff, red_in;
   rsp_type     rsp_ff, rsp_in;

   // configuration
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         box_ff <= '0;
      end else if (csr_valid && csr_ready &&
                   csr_index < CSR_INDEX_W'(NUM_BOX_REGS)) begin
         box_ff[csr_index] <= csr_data;
      end
   end

   // stage advance chain
   always_comb begin
      adv[NST-1] = !vld_ff[NST-1] || !rsp_stall;
      for (int k = NST - 2; k >= 0; k--) begin
         adv[k] = !vld_ff[k] || adv[k+1];
      end
   end

   assign req_stall = !adv[ST_DIFF];
   assign rsp_valid = vld_ff[ST_OUT];
   assign rsp_data  = rsp_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         if (adv[0]) begin
            vld_ff[0] <= req_valid;
         end
         for (int k = 1; k < NST; k++) begin
            if (adv[k]) begin
               vld_ff[k] <= vld_ff[k-1];
            end
         end
      end
   end

   // plane minus origin, and origin-inside test per axis
   always_comb begin
      logic [2:0][31:0] org;
      org = {req_data.origin_z, req_data.origin_y, req_data.origin_x};
      diff_in.dir = {req_data.direction_z, req_data.direction_y, req_data.direction_x};
      diff_in.side          = '0;
      diff_in.side.lim_near = req_data.limit_near;
      diff_in.side.lim_far  = req_data.limit_far;
      for (int a = 0; a < 3; a++) begin
         diff_in.diff[a]   = {box_ff[a][31], box_ff[a]} - {org[a][31], org[a]};
         diff_in.diff[a+3] = {box_ff[a+3][31], box_ff[a+3]} - {org[a][31], org[a]};
         diff_in.side.org_in[a] = ($signed(org[a]) >= $signed(box_ff[a])) &&
                                  ($signed(org[a]) <= $signed(box_ff[a+3]));
      end
   end

   // magnitudes and quotient signs
   always_comb begin
      logic [32:0] dm;
      mag_in.side = diff_ff.side;
      for (int a = 0; a < 3; a++) begin
         mag_in.dirmag[a] = diff_ff.dir[a][31] ? 32'(-diff_ff.dir[a]) : diff_ff.dir[a];
         mag_in.side.dir_zero[a] = (diff_ff.dir[a] == '0);
         mag_in.side.dir_neg[a]  = diff_ff.dir[a][31];
      end
      for (int i = 0; i < 6; i++) begin
         dm = diff_ff.diff[i][32] ? -diff_ff.diff[i] : diff_ff.diff[i];
         mag_in.dmag[i] = dm[31:0];
         mag_in.qneg[i] = diff_ff.diff[i][32] ^ diff_ff.dir[i % 3][31];
      end
   end

   // numerator is dmag * 2^16; upper 16 bits start the remainder
   always_comb begin
      init_in.dirmag = mag_ff.dirmag;
      init_in.side   = mag_ff.side;
      for (int i = 0; i < 6; i++) begin
         init_in.lane[i].rem = {16'd0, mag_ff.dmag[i][31:16]};
         init_in.lane[i].num = {mag_ff.dmag[i][15:0], 16'd0};
         init_in.lane[i].q   = '0;
         init_in.lane[i].ovf = ({16'd0, mag_ff.dmag[i][31:16]} >= mag_ff.dirmag[i % 3]);
         init_in.lane[i].neg = mag_ff.qneg[i];
      end
   end

   always_ff @(posedge clock) begin
      if (adv[ST_DIFF]) diff_ff <= diff_in;
      if (adv[ST_MAG])  mag_ff  <= mag_in;
      if (adv[ST_INIT]) init_ff <= init_in;
   end

   // restoring divider, two quotient bits per stage
   for (genvar j = 0; j < DIV_STAGES; j++) begin : g_div
      always_comb begin
         div_type src;
         src = (j == 0) ? init_ff : div_ff[(j == 0) ? 0 : j - 1];
         div_in[j] = src;
         for (int i = 0; i < 6; i++) begin
            div_in[j].lane[i] = div_step(src.lane[i], src.dirmag[i % 3]);
         end
      end

      always_ff @(posedge clock) begin
         if (adv[ST_DIV0 + j]) div_ff[j] <= div_in[j];
      end
   end

   // saturate quotients and pick entry/exit planes by direction sign (zero direction: by origin-inside test)
   always_comb begin
      div_type          dv;
      logic [5:0][31:0] t;
      dv = div_ff[DIV_STAGES-1];
      for (int i = 0; i < 6; i++) begin
         if (dv.lane[i].neg) begin
            if (dv.lane[i].ovf || dv.lane[i].q > 32'h8000_0000) t[i] = Q_MIN;
            else                                               t[i] = 32'(-dv.lane[i].q);
         end else begin
            if (dv.lane[i].ovf || dv.lane[i].q[31]) t[i] = Q_MAX;
            else                                    t[i] = dv.lane[i].q;
         end
      end
      sat_in.side = dv.side;
      for (int a = 0; a < 3; a++) begin
         if (dv.side.dir_zero[a]) begin
            sat_in.enter[a] = dv.side.org_in[a] ? Q_MIN : Q_MAX;
            sat_in.leave[a] = dv.side.org_in[a] ? Q_MAX : Q_MIN;
         end else if (dv.side.dir_neg[a]) begin
            sat_in.enter[a] = t[a+3];
            sat_in.leave[a] = t[a];
         end else begin
            sat_in.enter[a] = t[a];
            sat_in.leave[a] = t[a+3];
         end
      end
   end

   // max of entries and near limit, min of exits and far limit
   always_comb begin
      logic signed [31:0] e01, e2n, x01, x2f;
      e01 = ($signed(sat_ff.enter[1]) > $signed(sat_ff.enter[0])) ?
            sat_ff.enter[1] : sat_ff.enter[0];
      e2n = ($signed(sat_ff.enter[2]) > sat_ff.side.lim_near) ?
            sat_ff.enter[2] : sat_ff.side.lim_near;
      x01 = ($signed(sat_ff.leave[1]) < $signed(sat_ff.leave[0])) ?
            sat_ff.leave[1] : sat_ff.leave[0];
      x2f = ($signed(sat_ff.leave[2]) < sat_ff.side.lim_far) ?
            sat_ff.leave[2] : sat_ff.side.lim_far;
      red_in.entry = (e01 > e2n) ? e01 : e2n;
      red_in.exitd = (x01 < x2f) ? x01 : x2f;
   end

   always_comb begin
      rsp_in.entry_distance = red_ff.entry;
      rsp_in.exit_distance  = red_ff.exitd;
      rsp_in.box_hit        = (red_ff.entry < red_ff.exitd);
   end

   always_ff @(posedge clock) begin
      if (adv[ST_SAT]) sat_ff <= sat_in;
      if (adv[ST_RED]) red_ff <= red_in;
      if (adv[ST_OUT]) rsp_ff <= rsp_in;
   end

   a_accept_enters: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> vld_ff[ST_DIFF])
      else $error("accepted request did not enter the pipeline");

   a_stall_only_full: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (&vld_ff))
      else $error("request stalled while a pipeline stage was empty");

   a_zero_dir_miss: assert property (@(posedge clock) disable iff (reset)
      vld_ff[ST_SAT] && adv[ST_RED] && (|(sat_ff.side.dir_zero & ~sat_ff.side.org_in))
      |=> red_ff.entry == Q_MAX && red_ff.exitd == Q_MIN)
      else $error("zero-direction miss did not force an empty interval");

   a_out_refill: assert property (@(posedge clock) disable iff (reset)
      vld_ff[ST_RED] && adv[ST_RED] |=> rsp_valid)
      else $error("result lost between reduce and output stage");

endmodule

// ===== bench/ray_box_slab_intersect_unit_test.sv =====
`timescale 1ns / 1ps
module ray_box_slab_intersect_unit_test;
   import rbsi_pkg::*;

   localparam int WATCHDOG_LIMIT = 20000;
   localparam int DRAIN_CYCLES   = 40;
   localparam int RAYS_PER_PHASE = 160;
   localparam logic signed [31:0] ONE = 32'sh0001_0000;

   typedef struct {
      req_type ray;
      bit      typed;
      rsp_type want;
   } ray_row_type;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_valid = 1'b0;
   logic                   req_stall;
   req_type                req_data = '0;
   logic                   rsp_valid;
   logic                   rsp_stall = 1'b0;
   rsp_type                rsp_data;
   logic                   csr_valid = 1'b0;
   logic                   csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [31:0]            csr_data = '0;

   logic signed [31:0] box_q [NUM_BOX_REGS];
   rsp_type            pending_hits [$];
   ray_row_type        ray_rows [$];
   int                 mismatches = 0;
   int                 idle_cycles = 0;
   bit                 sender_quiet = 0;
   bit                 receiver_quiet = 0;
   bit                 hold_req = 0;

   ray_box_slab_intersect_unit dut (.*);

   always #5 clock = ~clock;

   function automatic longint sat_q(longint v);
      if (v > longint'(Q_MAX)) return longint'(Q_MAX);
      if (v < longint'(Q_MIN)) return longint'(Q_MIN);
      return v;
   endfunction

   // clipped entry/exit of a ray against the current box
   function automatic rsp_type slab_clip(req_type r);
      logic signed [31:0] org [3];
      logic signed [31:0] dir [3];
      longint lo, hi, o, d, en, ex, t_lo, t_hi, nr, fr;
      rsp_type res;
      org = '{r.origin_x, r.origin_y, r.origin_z};
      dir = '{r.direction_x, r.direction_y, r.direction_z};
      nr = r.limit_near;
      fr = r.limit_far;
      for (int a = 0; a < 3; a++) begin
         lo = box_q[a];
         hi = box_q[a+3];
         o  = org[a];
         d  = dir[a];
         if (d == 0) begin
            if (o >= lo && o <= hi) begin
               en = Q_MIN;
               ex = Q_MAX;
            end else begin
               en = Q_MAX;
               ex = Q_MIN;
            end
         end else begin
            t_lo = sat_q(((lo - o) * 65536) / d);
            t_hi = sat_q(((hi - o) * 65536) / d);
            en = (d < 0) ? t_hi : t_lo;
            ex = (d < 0) ? t_lo : t_hi;
         end
         if (en > nr) nr = en;
         if (ex < fr) fr = ex;
      end
      res.entry_distance = nr[31:0];
      res.exit_distance  = fr[31:0];
      res.box_hit        = (nr < fr);
      return res;
   endfunction

   function automatic req_type mk_ray(logic signed [31:0] ox, oy, oz, dx, dy, dz, n, f);
      return '{ox, oy, oz, dx, dy, dz, n, f};
   endfunction

   function automatic logic signed [31:0] rand_coord();
      case ($urandom_range(0, 9))
         0: case ($urandom_range(0, 4))
               0: return Q_MAX;
               1: return Q_MIN;
               2: return 32'sd1;
               3: return -32'sd1;
               default: return 32'sd0;
            endcase
         1, 2: return $urandom;
         default: return $signed($urandom_range(0, 32'h0014_0000)) - 32'sh000a_0000;
      endcase
   endfunction

   function automatic logic signed [31:0] rand_dir();
      if ($urandom_range(0, 5) == 0) return 32'sd0;
      return rand_coord();
   endfunction

   function automatic req_type rand_ray();
      req_type r;
      r = mk_ray(rand_coord(), rand_coord(), rand_coord(),
                 rand_dir(), rand_dir(), rand_dir(), 32'sd0, Q_MAX);
      if ($urandom_range(0, 2) == 0) r.limit_near = rand_coord();
      if ($urandom_range(0, 2) == 0) r.limit_far  = rand_coord();
      return r;
   endfunction

   function automatic int gap_len();
      int p;
      p = $urandom_range(0, 99);
      if (p < 55) return 0;
      if (p < 92) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   // called at a falling edge, returns at a falling edge
   task automatic write_box(logic [CSR_INDEX_W-1:0] idx, logic [31:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      if (idx < NUM_BOX_REGS) box_q[idx] = val;
      @(negedge clock);
      csr_valid <= 1'b0;
      @(negedge clock);
   endtask

   task automatic send_ray(req_type r, bit typed, rsp_type want);
      int g;
      req_valid <= 1'b1;
      req_data  <= r;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      pending_hits.push_back(typed ? want : slab_clip(r));
      @(negedge clock);
      g = sender_quiet ? 0 : gap_len();
      if (g > 0) begin
         req_valid <= 1'b0;
         repeat (g) @(negedge clock);
      end
   endtask

   task automatic wait_idle();
      req_valid <= 1'b0;
      while (pending_hits.size() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   // receiver: random stalls, plus a long hold-off on request
   initial begin
      int stall_left;
      stall_left = 0;
      forever begin
         @(negedge clock);
         if (hold_req) begin
            hold_req = 0;
            stall_left = 400;
         end
         if (stall_left > 0) begin
            stall_left--;
            rsp_stall <= 1'b1;
         end else if (receiver_quiet || $urandom_range(0, 99) < 70) begin
            rsp_stall <= 1'b0;
         end else begin
            stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 30)
                                                      : $urandom_range(1, 3);
            stall_left--;
            rsp_stall <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_hits.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected result entry=%h exit=%h hit=%b",
                        rsp_data.entry_distance, rsp_data.exit_distance, rsp_data.box_hit);
         end else begin
            want = pending_hits.pop_front();
            if (rsp_data !== want) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("mismatch: exp entry=%h exit=%h hit=%b, got entry=%h exit=%h hit=%b",
                           want.entry_distance, want.exit_distance, want.box_hit,
                           rsp_data.entry_distance, rsp_data.exit_distance, rsp_data.box_hit);
            end
         end
      end
   end

   // watchdog on cycles with no handshake at all
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || (csr_valid && csr_ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("ray_box_slab_intersect_unit_test: done, errors");
         $finish;
      end
   end

   initial begin
      rsp_type no_hit;
      rsp_type none;
      logic [31:0] v;
      for (int i = 0; i < NUM_BOX_REGS; i++) box_q[i] = '0;
      no_hit = '{Q_MAX, Q_MIN, 1'b0};
      none   = '0;

      // box is the point at the origin after reset
      ray_rows.push_back('{mk_ray(0, 0, 0, 0, 0, 0, 0, Q_MAX), 1, '{32'sd0, Q_MAX, 1'b1}});
      ray_rows.push_back('{mk_ray(1, 0, 0, 0, 0, 0, 0, Q_MAX), 1, no_hit});
      ray_rows.push_back('{mk_ray(0, -1, 0, 0, 0, 0, 0, Q_MAX), 1, no_hit});
      ray_rows.push_back('{mk_ray(0, 0, Q_MAX, 0, 0, 0, 0, Q_MAX), 1, no_hit});
      ray_rows.push_back('{mk_ray(0, 0, 0, 0, 0, 0, Q_MAX, Q_MIN), 1, no_hit});
      ray_rows.push_back('{mk_ray(0, 0, 0, 0, 0, 0, Q_MIN, Q_MAX), 1, '{Q_MIN, Q_MAX, 1'b1}});
      ray_rows.push_back('{mk_ray(0, 0, 0, 0, 0, 0, 5, 5), 1, '{32'sd5, 32'sd5, 1'b0}});
      ray_rows.push_back('{mk_ray(Q_MIN, 0, 0, 1, 0, 0, 0, Q_MAX), 0, none});
      ray_rows.push_back('{mk_ray(Q_MAX, 0, 0, -1, 0, 0, 0, Q_MAX), 0, none});
      ray_rows.push_back('{mk_ray(Q_MIN, Q_MIN, Q_MIN, Q_MAX, Q_MAX, Q_MAX, Q_MIN, Q_MAX), 0, none});
      ray_rows.push_back('{mk_ray(Q_MAX, Q_MAX, Q_MAX, Q_MIN, Q_MIN, Q_MIN, Q_MIN, Q_MAX), 0, none});
      ray_rows.push_back('{mk_ray(-ONE, -ONE, -ONE, ONE, ONE, ONE, 0, Q_MAX), 0, none});
      ray_rows.push_back('{mk_ray(ONE, ONE, ONE, -ONE, -ONE, -ONE, 0, Q_MAX), 0, none});
      ray_rows.push_back('{mk_ray(-ONE, 0, 0, ONE, 0, 0, 0, Q_MAX), 0, none});
      ray_rows.push_back('{mk_ray(-ONE, 0, 0, 1, 0, 0, Q_MIN, Q_MAX), 0, none});
      ray_rows.push_back('{mk_ray(ONE, ONE, 0, -3, 7, 0, 0, Q_MAX), 0, none});
      ray_rows.push_back('{mk_ray(-ONE, 0, 0, ONE, 0, ONE, 0, Q_MAX), 0, none});

      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      foreach (ray_rows[i]) send_ray(ray_rows[i].ray, ray_rows[i].typed, ray_rows[i].want);
      wait_idle();

      for (int ph = 1; ph <= 6; ph++) begin
         sender_quiet   = (ph == 4);
         receiver_quiet = (ph == 4);
         for (int i = 0; i < NUM_BOX_REGS; i++) begin
            case (ph)
               1: v = (i < 3) ? -4 * ONE : 4 * ONE;
               2: v = (i < 3) ? Q_MIN : Q_MAX;
               3: v = (i < 3) ? 3 * ONE : -3 * ONE;   // inverted box
               default: begin
                  v = rand_coord();
                  if (i >= 3 && $urandom_range(0, 4) != 0 && $signed(v) < box_q[i-3]) begin
                     v = box_q[i-3];
                     box_q[i-3] = rand_coord();
                     write_box(CSR_INDEX_W'(i - 3), v);
                     v = rand_coord();
                  end
               end
            endcase
            write_box(CSR_INDEX_W'(i), v);
         end
         if (ph >= 5) begin
            write_box(CSR_INDEX_W'(CSR_BOX_MAX_Z + 1), $urandom);
            write_box(CSR_INDEX_W'(CSR_BOX_MAX_Z + 2), $urandom);
         end
         if (ph == 2) hold_req = 1;
         repeat (RAYS_PER_PHASE) send_ray(rand_ray(), 0, none);
         wait_idle();
      end

      if (mismatches == 0 && pending_hits.size() == 0)
         $display("ray_box_slab_intersect_unit_test: done, clean");
      else
         $display("ray_box_slab_intersect_unit_test: done, errors");
      $finish;
   end

endmodule

// ===== sim.f =====
hw/rtl/rbsi_pkg.sv
hw/rtl/ray_box_slab_intersect_unit.sv
bench/ray_box_slab_intersect_unit_test.sv
